[hdl/qte_pkg.sv]
package qte_pkg;

    localparam int VW      = 38;
    localparam int ZW      = 28;
    localparam int SW      = 34;
    localparam int RW      = 57;
    localparam int AW      = 17;
    localparam int TAB_LEN = 24;
    localparam int SQ_BITS = 29;

    localparam logic signed [ZW-1:0] HALF_PI_Z   = 28'sd26353589;
    localparam logic signed [AW-1:0] PI_Q13      = 17'sd25736;
    localparam logic signed [AW-1:0] HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [SW-1:0] ONE_28      = 34'sd268435456;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } vec_t;

    typedef struct packed {
        vec_t roll;
        vec_t pitch;
        vec_t yaw;
        logic clamp;
        logic sneg;
    } cord_t;

    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [RW-1:0]        res;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] roll_y;
        logic signed [SW-1:0] roll_x;
        logic signed [SW-1:0] yaw_y;
        logic signed [SW-1:0] yaw_x;
        logic                 clamp;
    } sq_t;

    // atan(2^-i) at scale 2^24
    function automatic logic signed [ZW-1:0] atan_lut(input int unsigned idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/qte_sqrt_cell.sv]
module qte_sqrt_cell import qte_pkg::*; #(
    parameter int K = 28
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  sq_t  in_data,
    output logic out_valid,
    output sq_t  out_data
);

    localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

    logic  valid_reg;
    sq_t   data_reg;
    sq_t   data_next;
    logic [RW-1:0] trial;

    always_comb begin
        data_next = in_data;
        trial     = in_data.res + BIT;
        if (in_data.rem >= trial) begin
            data_next.rem = in_data.rem - trial;
            data_next.res = (in_data.res >> 1) + BIT;
        end else begin
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/qte_cordic_pre.sv]
module qte_cordic_pre import qte_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  cord_t in_data,
    output logic  out_valid,
    output cord_t out_data
);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    // fold left half plane into the right one
    function automatic vec_t pre(vec_t v);
        vec_t o;
        o      = v;
        o.z    = '0;
        o.zero = (v.x == '0) && (v.y == '0);
        if (v.x[VW-1]) begin
            if (!v.y[VW-1]) begin
                o.x = v.y;
                o.y = -v.x;
                o.z = HALF_PI_Z;
            end else begin
                o.x = -v.y;
                o.y = v.x;
                o.z = -HALF_PI_Z;
            end
        end
        return o;
    endfunction

    always_comb begin
        data_next       = in_data;
        data_next.roll  = pre(in_data.roll);
        data_next.pitch = pre(in_data.pitch);
        data_next.yaw   = pre(in_data.yaw);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/qte_cordic_cell.sv]
module qte_cordic_cell import qte_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  cord_t in_data,
    output logic  out_valid,
    output cord_t out_data
);

    localparam logic signed [ZW-1:0] ANG = atan_lut(STEP);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    function automatic vec_t rot(vec_t v);
        vec_t o;
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        o  = v;
        xs = v.x >>> STEP;
        ys = v.y >>> STEP;
        if (!v.y[VW-1]) begin
            o.x = v.x + ys;
            o.y = v.y - xs;
            o.z = v.z + ANG;
        end else begin
            o.x = v.x - ys;
            o.y = v.y + xs;
            o.z = v.z - ANG;
        end
        return o;
    endfunction

    always_comb begin
        data_next       = in_data;
        data_next.roll  = rot(in_data.roll);
        data_next.pitch = rot(in_data.pitch);
        data_next.yaw   = rot(in_data.yaw);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/quaternion_to_euler_angles_core.sv]
// channel | ports            | beat contents
// input   | s_t*             | quaternion w, x, y, z
// output  | m_t*             | roll, pitch, yaw angles and pitch clamp flag
//
// one beat per cycle while the output is not stalled (29 square-root cells)
// the pipeline runs through the row of square-root cells and the row of cordic cells
// the whole row advances together and halts while m_tvalid is high and m_tready low
// synchronous active-low reset clears all valid bits, no other start-up work
module quaternion_to_euler_angles_core import qte_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic [0:0]  m_tuser    // pitch_clamped
);

    localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    // products
    logic v1_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
        end
    end

    // sums
    logic v2_reg;
    logic signed [SW-1:0] ry_reg, rx_reg, yy2_reg, yx_reg, s_reg;
    logic signed [SW-1:0] s_next, abs_s;
    logic clamp_reg, clamp_next;
    logic [27:0] as_reg;

    assign s_next     = (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
    assign abs_s      = s_next[SW-1] ? -s_next : s_next;
    assign clamp_next = (s_next >= ONE_28) || (s_next <= -ONE_28);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ry_reg    <= (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
            rx_reg    <= ONE_28 - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
            yy2_reg   <= (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
            yx_reg    <= ONE_28 - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
            s_reg     <= s_next;
            clamp_reg <= clamp_next;
            as_reg    <= abs_s[27:0];
        end
    end

    // radicand
    logic v3_reg;
    sq_t  sq3_reg;
    sq_t  sq3_next;
    logic [55:0] asq;

    assign asq = as_reg * as_reg;

    always_comb begin
        sq3_next.rem    = {1'b1, 56'b0} - {1'b0, asq};
        sq3_next.res    = '0;
        sq3_next.s      = s_reg;
        sq3_next.roll_y = ry_reg;
        sq3_next.roll_x = rx_reg;
        sq3_next.yaw_y  = yy2_reg;
        sq3_next.yaw_x  = yx_reg;
        sq3_next.clamp  = clamp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq3_reg <= sq3_next;
        end
    end

    // square-root row
    sq_t  sq_d [0:SQ_BITS];
    logic sq_v [0:SQ_BITS];
    assign sq_d[0] = sq3_reg;
    assign sq_v[0] = v3_reg;

    for (genvar k = 0; k < SQ_BITS; k++) begin : g_sq
        qte_sqrt_cell #(.K(SQ_BITS - 1 - k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (sq_v[k]),
            .in_data   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_data  (sq_d[k+1])
        );
    end

    function automatic logic signed [VW-1:0] sx(logic signed [SW-1:0] v);
        return {{(VW-SW){v[SW-1]}}, v};
    endfunction

    cord_t cin;
    sq_t   sq_end;
    assign sq_end = sq_d[SQ_BITS];

    always_comb begin
        cin            = '0;
        cin.roll.x     = sx(sq_end.roll_x);
        cin.roll.y     = sx(sq_end.roll_y);
        cin.yaw.x      = sx(sq_end.yaw_x);
        cin.yaw.y      = sx(sq_end.yaw_y);
        cin.pitch.x    = {{(VW-29){1'b0}}, sq_end.res[28:0]};
        cin.pitch.y    = sx(sq_end.s);
        cin.clamp      = sq_end.clamp;
        cin.sneg       = sq_end.s[SW-1];
    end

    // cordic row
    cord_t cd_d [0:NSTEP];
    logic  cd_v [0:NSTEP];

    qte_cordic_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_v[SQ_BITS]),
        .in_data   (cin),
        .out_valid (cd_v[0]),
        .out_data  (cd_d[0])
    );

    for (genvar i = 0; i < NSTEP; i++) begin : g_cd
        qte_cordic_cell #(.STEP(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (cd_v[i]),
            .in_data   (cd_d[i]),
            .out_valid (cd_v[i+1]),
            .out_data  (cd_d[i+1])
        );
    end

    function automatic logic signed [AW-1:0] fin_ang(vec_t v);
        logic signed [ZW-1:0] zr;
        logic signed [AW-1:0] r;
        zr = v.z + ZW'(1024);
        r  = AW'(zr >>> 11);
        if (v.zero) begin
            r = '0;
        end else if (r > PI_Q13) begin
            r = PI_Q13;
        end else if (r < -PI_Q13) begin
            r = -PI_Q13;
        end
        return r;
    endfunction

    // output register
    cord_t cend;
    logic signed [AW-1:0] roll_a, yaw_a, pa, pitch_a;
    logic m_valid_reg;
    logic [47:0] m_data_reg;
    logic m_user_reg;

    assign cend   = cd_d[NSTEP];
    assign roll_a = fin_ang(cend.roll);
    assign yaw_a  = fin_ang(cend.yaw);
    assign pa     = fin_ang(cend.pitch);

    always_comb begin
        if (cend.clamp) begin
            pitch_a = cend.sneg ? -HALF_PI_Q13 : HALF_PI_Q13;
        end else if (pa > HALF_PI_Q13) begin
            pitch_a = HALF_PI_Q13;
        end else if (pa < -HALF_PI_Q13) begin
            pitch_a = -HALF_PI_Q13;
        end else begin
            pitch_a = pa;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= cd_v[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {1'b0, yaw_a[15:0], pitch_a[14:0], roll_a[15:0]};
            m_user_reg <= cend.clamp;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    a_clamp_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[30:16] == 15'sd12868)
            || (m_tdata[30:16] == -15'sd12868))
        else $error("clamped pitch not at a right angle");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736)
            && ($signed(m_tdata[15:0]) >= -16'sd25736))
        else $error("roll out of range");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47] == 1'b0))
        else $error("pad bit set");

endmodule
